[rtl/core/segx_pkg.sv]
// Shared constants and types for the 2D segment intersection pipeline.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package segx_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed output field widths
    localparam int PARAM_W = 32;
    localparam int POINT_W = 48;

    // quotient bits produced by every divider (covers the widest output)
    localparam int QUO_W = POINT_W;

    // register stages in the front end and in one divider
    localparam int FRONT_LAT = 5;
    localparam int DIV_LAT   = QUO_W + 3;

    // flags computed in the front end and carried beside the dividers
    typedef struct packed {
        logic exists;
        logic parallel;
    } segx_flags_t;

endpackage
`default_nettype wire

[rtl/core/segx_in_if.sv]
// Input channel: one word holds the two segments' endpoints.
// Depends on segx_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface segx_in_if #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/segx_out_if.sv]
// Output channel: one word holds the crossing flags, parameters and point.
// Depends on segx_pkg for the output field widths.
`timescale 1ns / 1ps
`default_nettype none
interface segx_out_if;
    logic                                valid;
    logic                                ready;
    logic                                crossing_exists;
    logic                                lines_parallel;
    logic signed [segx_pkg::PARAM_W-1:0] param_first;
    logic signed [segx_pkg::PARAM_W-1:0] param_second;
    logic signed [segx_pkg::POINT_W-1:0] point_x;
    logic signed [segx_pkg::POINT_W-1:0] point_y;

    modport source (
        output valid, crossing_exists, lines_parallel, param_first, param_second,
               point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, crossing_exists, lines_parallel, param_first, param_second,
               point_x, point_y,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/segx_front.sv]
// Front end: differences, cross products, numerators, denominator and flags.
// Five register stages; depends on segx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module segx_front #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [COORD_BITS-1:0]      ax,
    input  wire logic signed [COORD_BITS-1:0]      ay,
    input  wire logic signed [COORD_BITS-1:0]      bx,
    input  wire logic signed [COORD_BITS-1:0]      by,
    input  wire logic signed [COORD_BITS-1:0]      cx,
    input  wire logic signed [COORD_BITS-1:0]      cy,
    input  wire logic signed [COORD_BITS-1:0]      dx,
    input  wire logic signed [COORD_BITS-1:0]      dy,
    output logic signed [2*COORD_BITS+2:0]         num_a,
    output logic signed [2*COORD_BITS+2:0]         num_b,
    output logic signed [2*COORD_BITS+2:0]         den,
    output logic signed [3*COORD_BITS+4:0]         num_px,
    output logic signed [3*COORD_BITS+4:0]         num_py,
    output segx_pkg::segx_flags_t                  flags
);
    import segx_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int NW  = 2 * CW + 3;
    localparam int MW1 = CW + NW;
    localparam int MW2 = NW + DW;
    localparam int XW  = 3 * CW + 5;

    // stage 1
    logic signed [CW-1:0] ax1_reg, ay1_reg;
    logic signed [DW-1:0] dax1_reg, day1_reg, dcx1_reg, dcy1_reg, ox1_reg, oy1_reg;
    // stage 2
    logic signed [CW-1:0] ax2_reg, ay2_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [PW-1:0] p_cxoy_reg, p_cyox_reg, p_axoy_reg, p_ayox_reg;
    logic signed [PW-1:0] p_cyax_reg, p_cxay_reg;
    // stage 3
    logic signed [CW-1:0] ax3_reg, ay3_reg;
    logic signed [DW-1:0] dax3_reg, day3_reg;
    logic signed [NW-1:0] na3_reg, nb3_reg, den3_reg;
    // stage 4
    logic signed [NW-1:0]  na4_reg, nb4_reg, den4_reg;
    logic signed [MW1-1:0] m_axd_reg, m_ayd_reg;
    logic signed [MW2-1:0] m_nax_reg, m_nay_reg;
    segx_flags_t           flags4_reg, flags4_next;
    // stage 5
    logic signed [NW-1:0] na5_reg, nb5_reg, den5_reg;
    logic signed [XW-1:0] px5_reg, py5_reg;
    segx_flags_t          flags5_reg;

    logic in_a, in_b, den_pos;

    // classify the crossing exactly from signs and magnitudes
    always_comb
    begin
        den_pos = !den3_reg[NW-1];
        if (den_pos)
        begin
            in_a = !na3_reg[NW-1] && (na3_reg <= den3_reg);
            in_b = !nb3_reg[NW-1] && (nb3_reg <= den3_reg);
        end
        else
        begin
            in_a = (den3_reg <= na3_reg) && (na3_reg <= NW'(0));
            in_b = (den3_reg <= nb3_reg) && (nb3_reg <= NW'(0));
        end
        flags4_next.parallel = (den3_reg == NW'(0));
        flags4_next.exists   = in_a && in_b && !flags4_next.parallel;
    end

    // advance all five stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            dax1_reg <= DW'(bx) - DW'(ax);
            day1_reg <= DW'(by) - DW'(ay);
            dcx1_reg <= DW'(dx) - DW'(cx);
            dcy1_reg <= DW'(dy) - DW'(cy);
            ox1_reg  <= DW'(ax) - DW'(cx);
            oy1_reg  <= DW'(ay) - DW'(cy);

            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            dax2_reg   <= dax1_reg;
            day2_reg   <= day1_reg;
            p_cxoy_reg <= dcx1_reg * oy1_reg;
            p_cyox_reg <= dcy1_reg * ox1_reg;
            p_axoy_reg <= dax1_reg * oy1_reg;
            p_ayox_reg <= day1_reg * ox1_reg;
            p_cyax_reg <= dcy1_reg * dax1_reg;
            p_cxay_reg <= dcx1_reg * day1_reg;

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            na3_reg  <= NW'(p_cxoy_reg) - NW'(p_cyox_reg);
            nb3_reg  <= NW'(p_axoy_reg) - NW'(p_ayox_reg);
            den3_reg <= NW'(p_cyax_reg) - NW'(p_cxay_reg);

            na4_reg    <= na3_reg;
            nb4_reg    <= nb3_reg;
            den4_reg   <= den3_reg;
            m_axd_reg  <= ax3_reg * den3_reg;
            m_ayd_reg  <= ay3_reg * den3_reg;
            m_nax_reg  <= na3_reg * dax3_reg;
            m_nay_reg  <= na3_reg * day3_reg;
            flags4_reg <= flags4_next;

            na5_reg    <= na4_reg;
            nb5_reg    <= nb4_reg;
            den5_reg   <= den4_reg;
            px5_reg    <= XW'(m_axd_reg) + XW'(m_nax_reg);
            py5_reg    <= XW'(m_ayd_reg) + XW'(m_nay_reg);
            flags5_reg <= flags4_reg;
        end
    end

    assign num_a  = na5_reg;
    assign num_b  = nb5_reg;
    assign den    = den5_reg;
    assign num_px = px5_reg;
    assign num_py = py5_reg;
    assign flags  = flags5_reg;

endmodule
`default_nettype wire

[rtl/core/segx_div.sv]
// Pipelined signed fixed-point divider: one quotient bit per stage,
// truncating toward zero, saturated to OUT_W bits. Depends on segx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module segx_div #(
    parameter int NUM_W  = 35,
    parameter int DEN_W  = 35,
    parameter int FRAC_W = segx_pkg::FRAC_BITS_DEF,
    parameter int QUO_W  = segx_pkg::QUO_W,
    parameter int OUT_W  = segx_pkg::PARAM_W
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic signed [DEN_W-1:0]  den,
    output logic signed [OUT_W-1:0]       quo
);
    import segx_pkg::*;

    localparam int SW = NUM_W + FRAC_W;          // scaled numerator
    localparam int XW = SW + DEN_W + QUO_W;      // room for the overflow compare

    // stage a: magnitudes and sign
    logic             neg_a_reg;
    logic [SW-1:0]    nsh_a_reg;
    logic [DEN_W-1:0] dmag_a_reg;
    logic [NUM_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;

    // iteration stages, index 0 is the overflow stage
    logic             neg_reg  [QUO_W+1];
    logic             ovf_reg  [QUO_W+1];
    logic [DEN_W-1:0] dv_reg   [QUO_W+1];
    logic [DEN_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0] low_reg  [QUO_W+1];
    logic [QUO_W-1:0] q_reg    [QUO_W+1];

    logic [XW-1:0]    wide_n, wide_hi;
    logic [QUO_W-1:0] lim, mag;
    logic signed [OUT_W-1:0] quo_reg;

    assign nmag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    assign dmag = den[DEN_W-1] ? (~den + DEN_W'(1)) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
            nsh_a_reg  <= {nmag, FRAC_W'(0)};
            dmag_a_reg <= dmag;
        end
    end

    // split the scaled numerator: high part checks overflow, low part is shifted in
    assign wide_n  = XW'(nsh_a_reg);
    assign wide_hi = wide_n >> QUO_W;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= (wide_hi >= XW'(dmag_a_reg));
            dv_reg[0]  <= dmag_a_reg;
            rem_reg[0] <= wide_hi[DEN_W-1:0];
            low_reg[0] <= wide_n[QUO_W-1:0];
            q_reg[0]   <= '0;
        end
    end

    // one restoring step per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           take;
        assign trial = {rem_reg[k], low_reg[k][QUO_W-1]};
        assign take  = (trial >= {1'b0, dv_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                dv_reg[k+1]  <= dv_reg[k];
                rem_reg[k+1] <= take ? DEN_W'(trial - {1'b0, dv_reg[k]})
                                     : DEN_W'(trial);
                low_reg[k+1] <= low_reg[k] << 1;
                q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], take};
            end
        end
    end

    // saturate and apply sign
    always_comb
    begin
        lim = (QUO_W'(1) << (OUT_W - 1)) - QUO_W'(!neg_reg[QUO_W]);
        mag = (ovf_reg[QUO_W] || (q_reg[QUO_W] > lim)) ? lim : q_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[QUO_W] ? -OUT_W'(mag) : OUT_W'(mag);
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

[rtl/core/segment_intersection_2d.sv]
// Top level of the 2D segment intersection pipeline.
// Depends on segx_pkg, segx_in_if, segx_out_if, segx_front and segx_div.
//
// Usage:
//   seg_in carries one word per pair of segments (A->B, C->D), seg_out one
//   word per input word, in order: crossing flags, ua and ub with FRAC_BITS
//   fraction bits (32 bits), and the crossing point (48 bits), all truncated
//   toward zero and saturated. Parallel lines give lines_parallel = 1 and
//   zeros elsewhere.
//   Pipeline: 5 front-end stages, 51 divider stages, one output register.
//   Throughput: one word per cycle while seg_out does not stall; the divider
//   yields one quotient bit per stage, over 48 iteration stages.
//   Four dividers (ua, ub, x, y) run side by side.
//   Reset clears all valid bits; the pipeline is empty after reset.
//   When seg_out.ready is low with a word waiting, the whole pipeline holds
//   and seg_in.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_2d #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segx_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    segx_in_if.sink    seg_in,
    segx_out_if.source seg_out
);
    import segx_pkg::*;

    localparam int NW    = 2 * COORD_BITS + 3;
    localparam int XW    = 3 * COORD_BITS + 5;
    localparam int DEPTH = FRONT_LAT + DIV_LAT + 1;

    logic             en;
    logic [DEPTH-1:0] vld_reg;

    logic signed [NW-1:0] num_a, num_b, den;
    logic signed [XW-1:0] num_px, num_py;
    segx_flags_t          flags;
    segx_flags_t          flg_reg [DIV_LAT];

    logic signed [PARAM_W-1:0] qa, qb;
    logic signed [POINT_W-1:0] qx, qy;

    logic                      exists_reg, parallel_reg;
    logic signed [PARAM_W-1:0] pa_reg, pb_reg;
    logic signed [POINT_W-1:0] px_reg, py_reg;

    // advance whenever the output word is empty or being taken
    assign en           = !vld_reg[DEPTH-1] || seg_out.ready;
    assign seg_in.ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], seg_in.valid};
        end
    end

    segx_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .en     (en),
        .ax     (seg_in.first_start_x),
        .ay     (seg_in.first_start_y),
        .bx     (seg_in.first_end_x),
        .by     (seg_in.first_end_y),
        .cx     (seg_in.second_start_x),
        .cy     (seg_in.second_start_y),
        .dx     (seg_in.second_end_x),
        .dy     (seg_in.second_end_y),
        .num_a  (num_a),
        .num_b  (num_b),
        .den    (den),
        .num_px (num_px),
        .num_py (num_py),
        .flags  (flags)
    );

    segx_div #(
        .NUM_W (NW), .DEN_W (NW), .FRAC_W (FRAC_BITS), .QUO_W (QUO_W), .OUT_W (PARAM_W)
    ) u_div_a (
        .clk (clk), .en (en), .num (num_a), .den (den), .quo (qa)
    );

    segx_div #(
        .NUM_W (NW), .DEN_W (NW), .FRAC_W (FRAC_BITS), .QUO_W (QUO_W), .OUT_W (PARAM_W)
    ) u_div_b (
        .clk (clk), .en (en), .num (num_b), .den (den), .quo (qb)
    );

    segx_div #(
        .NUM_W (XW), .DEN_W (NW), .FRAC_W (FRAC_BITS), .QUO_W (QUO_W), .OUT_W (POINT_W)
    ) u_div_x (
        .clk (clk), .en (en), .num (num_px), .den (den), .quo (qx)
    );

    segx_div #(
        .NUM_W (XW), .DEN_W (NW), .FRAC_W (FRAC_BITS), .QUO_W (QUO_W), .OUT_W (POINT_W)
    ) u_div_y (
        .clk (clk), .en (en), .num (num_py), .den (den), .quo (qy)
    );

    // delay the flags alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[0] <= flags;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    // output word: force zeros for parallel lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exists_reg   <= flg_reg[DIV_LAT-1].exists;
            parallel_reg <= flg_reg[DIV_LAT-1].parallel;
            pa_reg       <= flg_reg[DIV_LAT-1].parallel ? '0 : qa;
            pb_reg       <= flg_reg[DIV_LAT-1].parallel ? '0 : qb;
            px_reg       <= flg_reg[DIV_LAT-1].parallel ? '0 : qx;
            py_reg       <= flg_reg[DIV_LAT-1].parallel ? '0 : qy;
        end
    end

    assign seg_out.valid           = vld_reg[DEPTH-1];
    assign seg_out.crossing_exists = exists_reg;
    assign seg_out.lines_parallel  = parallel_reg;
    assign seg_out.param_first     = pa_reg;
    assign seg_out.param_second    = pb_reg;
    assign seg_out.point_x         = px_reg;
    assign seg_out.point_y         = py_reg;

    // parallel lines carry no crossing and zero parameters
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && seg_out.lines_parallel |->
            !seg_out.crossing_exists && seg_out.param_first == 0 &&
            seg_out.param_second == 0 && seg_out.point_x == 0)
        else $error("parallel word with nonzero outputs");

    // a crossing keeps both parameters within zero to one
    a_exists_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && seg_out.crossing_exists |->
            seg_out.param_first >= 0 &&
            seg_out.param_first <= (PARAM_W'(1) << FRAC_BITS) &&
            seg_out.param_second >= 0 &&
            seg_out.param_second <= (PARAM_W'(1) << FRAC_BITS))
        else $error("crossing flagged with parameter out of range");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !seg_out.valid |-> seg_in.ready)
        else $error("input stalled with empty output");

    // a stalled output word freezes the pipeline contents
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && !seg_out.ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
